>>> src/bprs_pkg.sv
// Shared constants, codes and controller/datapath interface types for the byte pattern search.
package bprs_pkg;

    // Buffer depths
    localparam int HAYSTACK_DEPTH = 4096;
    localparam int NEEDLE_DEPTH   = 64;

    // Fixed field widths
    localparam int CMD_W  = 3;
    localparam int BYTE_W = 8;
    localparam int LOC_W  = 13;
    localparam int MLEN_W = 7;

    // Derived storage widths
    localparam int HAY_AW  = $clog2(HAYSTACK_DEPTH);
    localparam int HAY_CW  = $clog2(HAYSTACK_DEPTH + 1);
    localparam int NDL_AW  = (NEEDLE_DEPTH > 1) ? $clog2(NEEDLE_DEPTH) : 1;
    localparam int NDL_CW  = $clog2(NEEDLE_DEPTH + 1);
    localparam int POS_W   = (HAY_CW > LOC_W) ? HAY_CW : LOC_W;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR_HAY     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND_HAY    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR_NEEDLE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_APPEND_NEEDLE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEARCH        = 3'd4;

    // Search setup outcome
    localparam logic [1:0] SK_NONE  = 2'd0;
    localparam logic [1:0] SK_EMPTY = 2'd1;
    localparam logic [1:0] SK_SCAN  = 2'd2;

    // Result kind
    localparam logic [1:0] RES_NONE  = 2'd0;
    localparam logic [1:0] RES_EMPTY = 2'd1;
    localparam logic [1:0] RES_MATCH = 2'd2;

    typedef struct packed {
        logic       accept;
        logic       setup;
        logic       step_k;
        logic       next_pos;
        logic       load_result;
        logic [1:0] res_kind;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] setup_kind;
        logic       byte_eq;
        logic       k_last;
        logic       pos_last;
    } t_dp_status;

endpackage

>>> src/bprs_datapath.sv
// Datapath: haystack and needle memories, search position counters and result register.
module bprs_datapath
    import bprs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd_bus,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic [LOC_W-1:0]  i_range_start,
    input  logic [LOC_W-1:0]  i_range_length,
    input  logic              i_backwards,
    output t_dp_status        o_status,
    output logic              o_found,
    output logic [LOC_W-1:0]  o_match_location,
    output logic [MLEN_W-1:0] o_match_length
);

    logic [BYTE_W-1:0] r_hay_mem [HAYSTACK_DEPTH];
    logic [BYTE_W-1:0] r_ndl_mem [NEEDLE_DEPTH];
    logic [HAY_CW-1:0] r_hay_count;
    logic [NDL_CW-1:0] r_ndl_count;
    logic [BYTE_W-1:0] r_hay_q;
    logic [BYTE_W-1:0] r_ndl_q;

    logic [LOC_W-1:0]  r_start;
    logic [LOC_W-1:0]  r_len;
    logic              r_back;
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  r_end;
    logic [NDL_AW-1:0] r_k;

    logic              r_found;
    logic [LOC_W-1:0]  r_loc;
    logic [MLEN_W-1:0] r_mlen;

    logic [POS_W-1:0]  start_x;
    logic [POS_W-1:0]  len_x;
    logic [POS_W-1:0]  cnt_x;
    logic [POS_W-1:0]  ndl_x;
    logic [POS_W-1:0]  avail;
    logic [POS_W-1:0]  len_c;
    logic [POS_W-1:0]  last_pos;
    logic [POS_W-1:0]  empty_loc;
    logic [HAY_AW-1:0] hay_addr;
    logic              hay_full;
    logic              ndl_full;

    assign hay_full = (r_hay_count == HAY_CW'(HAYSTACK_DEPTH));
    assign ndl_full = (r_ndl_count == NDL_CW'(NEEDLE_DEPTH));

    // Hold buffer fill counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hay_count <= '0;
            r_ndl_count <= '0;
        end else if (i_cmd_bus.accept) begin
            unique case (i_cmd)
                CMD_CLEAR_HAY:     r_hay_count <= '0;
                CMD_APPEND_HAY:    if (!hay_full) r_hay_count <= r_hay_count + 1'b1;
                CMD_CLEAR_NEEDLE:  r_ndl_count <= '0;
                CMD_APPEND_NEEDLE: if (!ndl_full) r_ndl_count <= r_ndl_count + 1'b1;
                default: ;
            endcase
        end
    end

    // Write appended bytes into the buffers
    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.accept && i_cmd == CMD_APPEND_HAY && !hay_full) begin
            r_hay_mem[r_hay_count[HAY_AW-1:0]] <= i_data_byte;
        end
        if (i_cmd_bus.accept && i_cmd == CMD_APPEND_NEEDLE && !ndl_full) begin
            r_ndl_mem[r_ndl_count[NDL_AW-1:0]] <= i_data_byte;
        end
    end

    // Read the byte pair under compare
    assign hay_addr = r_pos[HAY_AW-1:0] + HAY_AW'(r_k);
    always_ff @(posedge i_clk) begin
        r_hay_q <= r_hay_mem[hay_addr];
        r_ndl_q <= r_ndl_mem[r_k];
    end

    // Capture the search transaction fields
    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.accept && i_cmd == CMD_SEARCH) begin
            r_start <= i_range_start;
            r_len   <= i_range_length;
            r_back  <= i_backwards;
        end
    end

    // Clamp the range and find the scan bounds
    always_comb begin
        start_x   = POS_W'(r_start);
        len_x     = POS_W'(r_len);
        cnt_x     = POS_W'(r_hay_count);
        ndl_x     = POS_W'(r_ndl_count);
        avail     = cnt_x - start_x;
        len_c     = (len_x > avail) ? avail : len_x;
        last_pos  = start_x + len_c - ndl_x;
        empty_loc = r_back ? (start_x + len_c) : start_x;
        priority if (start_x > cnt_x) begin
            o_status.setup_kind = SK_NONE;
        end else if (r_ndl_count == '0) begin
            o_status.setup_kind = SK_EMPTY;
        end else if (len_c < ndl_x) begin
            o_status.setup_kind = SK_NONE;
        end else begin
            o_status.setup_kind = SK_SCAN;
        end
        o_status.byte_eq  = (r_hay_q == r_ndl_q);
        o_status.k_last   = (NDL_CW'(r_k) == r_ndl_count - 1'b1);
        o_status.pos_last = (r_pos == r_end);
    end

    // Advance the candidate position and needle index
    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.setup) begin
            r_pos <= r_back ? last_pos : start_x;
            r_end <= r_back ? start_x : last_pos;
            r_k   <= '0;
        end else if (i_cmd_bus.next_pos) begin
            r_pos <= r_back ? (r_pos - 1'b1) : (r_pos + 1'b1);
            r_k   <= '0;
        end else if (i_cmd_bus.step_k) begin
            r_k   <= r_k + 1'b1;
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.load_result) begin
            unique case (i_cmd_bus.res_kind)
                RES_MATCH: begin
                    r_found <= 1'b1;
                    r_loc   <= r_pos[LOC_W-1:0];
                    r_mlen  <= MLEN_W'(r_ndl_count);
                end
                RES_EMPTY: begin
                    r_found <= 1'b1;
                    r_loc   <= empty_loc[LOC_W-1:0];
                    r_mlen  <= '0;
                end
                default: begin
                    r_found <= 1'b0;
                    r_loc   <= '0;
                    r_mlen  <= '0;
                end
            endcase
        end
    end

    assign o_found          = r_found;
    assign o_match_location = r_loc;
    assign o_match_length   = r_mlen;

endmodule

>>> src/bprs_controller.sv
// Controller: sequences loads, search setup, byte compares and result handoff.
module bprs_controller
    import bprs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [CMD_W-1:0] i_cmd,
    input  logic             i_stall,
    input  t_dp_status       i_status,
    output t_dp_cmd          o_cmd_bus,
    output logic             o_stall,
    output logic             o_valid
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [1:0] r_res_kind;
    logic [1:0] n_res_kind;
    logic       r_out_valid;
    logic       out_free;
    logic       accept;

    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign o_valid  = r_out_valid;

    // Decode next state and datapath commands
    always_comb begin
        n_state               = r_state;
        n_res_kind            = r_res_kind;
        o_cmd_bus             = '0;
        o_cmd_bus.accept      = accept;
        o_cmd_bus.res_kind    = r_res_kind;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_cmd == CMD_SEARCH) n_state = S_SETUP;
            end
            S_SETUP: begin
                unique case (i_status.setup_kind)
                    SK_EMPTY: begin
                        n_res_kind = RES_EMPTY;
                        n_state    = S_DONE;
                    end
                    SK_SCAN: begin
                        o_cmd_bus.setup = 1'b1;
                        n_state         = S_READ;
                    end
                    default: begin
                        n_res_kind = RES_NONE;
                        n_state    = S_DONE;
                    end
                endcase
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                priority if (i_status.byte_eq && i_status.k_last) begin
                    n_res_kind = RES_MATCH;
                    n_state    = S_DONE;
                end else if (i_status.byte_eq) begin
                    o_cmd_bus.step_k = 1'b1;
                    n_state          = S_READ;
                end else if (i_status.pos_last) begin
                    n_res_kind = RES_NONE;
                    n_state    = S_DONE;
                end else begin
                    o_cmd_bus.next_pos = 1'b1;
                    n_state            = S_READ;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd_bus.load_result = 1'b1;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Advance state and result kind
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_res_kind <= RES_NONE;
        end else begin
            r_state    <= n_state;
            r_res_kind <= n_res_kind;
        end
    end

    // Hold output valid until the transaction is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd_bus.load_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

>>> src/byte_pattern_range_search_unit.sv
// Top level of the byte pattern range search unit.
// Load commands (clear and append for haystack and needle) are accepted back to back,
// also while a search result waits at the output. A search transaction stalls the input
// until its result sits in the output register: a setup step, then for each byte compare
// a read through the registered memory read ports and then the compare, then a step to
// load the result, plus any wait while an earlier result still sits at the stalled
// output; the compare count is up to range length times needle length in the worst case.
// Setup clamps the range to the haystack fill; a start past the fill or a range shorter
// than the needle reports not found, and an empty needle reports the range start
// (forward) or range end (backwards) with zero length.
module byte_pattern_range_search_unit
    import bprs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic [LOC_W-1:0]  i_range_start,
    input  logic [LOC_W-1:0]  i_range_length,
    input  logic              i_backwards,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_found,
    output logic [LOC_W-1:0]  o_match_location,
    output logic [MLEN_W-1:0] o_match_length
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    bprs_controller u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_cmd     (i_cmd),
        .i_stall   (i_stall),
        .i_status  (dp_status),
        .o_cmd_bus (dp_cmd),
        .o_stall   (o_stall),
        .o_valid   (o_valid)
    );

    bprs_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_bus        (dp_cmd),
        .i_cmd            (i_cmd),
        .i_data_byte      (i_data_byte),
        .i_range_start    (i_range_start),
        .i_range_length   (i_range_length),
        .i_backwards      (i_backwards),
        .o_status         (dp_status),
        .o_found          (o_found),
        .o_match_location (o_match_location),
        .o_match_length   (o_match_length)
    );

    // A search transaction blocks further input on the next cycle
    a_search_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_cmd == CMD_SEARCH) |=> o_stall)
        else $error("search accepted without blocking input");

    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.load_result |-> (!o_valid || !i_stall))
        else $error("result register overwritten while stalled");

    // A not-found result carries zero location and length
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_match_location == '0 && o_match_length == '0))
        else $error("not-found result with nonzero fields");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the byte pattern range search unit.
module testbench;
    import bprs_pkg::*;

    // Command codes the block ignores
    localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    localparam logic [LOC_W-1:0] LOC_MAX       = '1;
    localparam int               RANDOM_ITEMS  = 1630;
    localparam int               HOLD_CYCLES   = 600;
    localparam int               DRAIN_CYCLES  = 40;
    localparam int               SMALL_HAY     = 48;
    localparam int               FULL_CASE_HAY = 160;

    typedef struct packed {
        logic              found;
        logic [LOC_W-1:0]  location;
        logic [MLEN_W-1:0] length;
    } t_match;

    // Mirror of both byte buffers; predicts each search and checks the results in order
    class t_match_checker;
        logic [BYTE_W-1:0] hay_bytes [HAYSTACK_DEPTH];
        logic [BYTE_W-1:0] needle_bytes [NEEDLE_DEPTH];
        int unsigned       hay_fill;
        int unsigned       needle_fill;
        t_match            pending [$];
        int unsigned       mismatches;

        function new();
            hay_fill    = 0;
            needle_fill = 0;
            mismatches  = 0;
        endfunction

        // Compare the whole needle against the haystack at one position
        function bit needle_at(int unsigned pos);
            for (int unsigned k = 0; k < needle_fill; k++) begin
                if (hay_bytes[pos + k] !== needle_bytes[k])
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        // Clamp the range to the fill, then scan in the requested direction
        function t_match search_range(int unsigned start, int unsigned span, bit back);
            t_match res;
            int     lo;
            int     hi;
            int     pos;
            res = '0;
            if (start > hay_fill)
                return res;
            if (span > hay_fill - start)
                span = hay_fill - start;
            if (needle_fill == 0) begin
                res.found    = 1'b1;
                res.location = LOC_W'(back ? start + span : start);
                return res;
            end
            if (span < needle_fill)
                return res;
            lo = start;
            hi = start + span - needle_fill;
            for (int i = 0; i <= hi - lo; i++) begin
                pos = back ? hi - i : lo + i;
                if (needle_at(pos)) begin
                    res.found    = 1'b1;
                    res.location = LOC_W'(pos);
                    res.length   = MLEN_W'(needle_fill);
                    return res;
                end
            end
            return res;
        endfunction

        // Apply one accepted transaction to the mirror
        function void take_command(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] data,
                                   logic [LOC_W-1:0] start, logic [LOC_W-1:0] span,
                                   logic back);
            case (cmd)
                CMD_CLEAR_HAY: begin
                    hay_fill = 0;
                end
                CMD_APPEND_HAY: begin
                    if (hay_fill < HAYSTACK_DEPTH) begin
                        hay_bytes[hay_fill] = data;
                        hay_fill++;
                    end
                end
                CMD_CLEAR_NEEDLE: begin
                    needle_fill = 0;
                end
                CMD_APPEND_NEEDLE: begin
                    if (needle_fill < NEEDLE_DEPTH) begin
                        needle_bytes[needle_fill] = data;
                        needle_fill++;
                    end
                end
                CMD_SEARCH: begin
                    pending.push_back(search_range(start, span, back));
                end
                default: ;
            endcase
        endfunction

        // Compare one result with the oldest prediction
        function void check_match(t_match got);
            t_match want;
            if (pending.size() == 0) begin
                $display("%0t: result with no search waiting: found %0d location %0d length %0d",
                         $time, got.found, got.location, got.length);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            if (got.found !== want.found) begin
                $display("%0t: found: expected %0d, actual %0d", $time, want.found, got.found);
                mismatches++;
            end
            if (got.location !== want.location) begin
                $display("%0t: match_location: expected %0d, actual %0d",
                         $time, want.location, got.location);
                mismatches++;
            end
            if (got.length !== want.length) begin
                $display("%0t: match_length: expected %0d, actual %0d",
                         $time, want.length, got.length);
                mismatches++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n        = 1'b0;
    logic              i_valid        = 1'b0;
    logic [CMD_W-1:0]  i_cmd          = '0;
    logic [BYTE_W-1:0] i_data_byte    = '0;
    logic [LOC_W-1:0]  i_range_start  = '0;
    logic [LOC_W-1:0]  i_range_length = '0;
    logic              i_backwards    = 1'b0;
    logic              i_stall        = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic              o_found;
    logic [LOC_W-1:0]  o_match_location;
    logic [MLEN_W-1:0] o_match_length;

    t_match_checker board;
    int             burst_left   = 0;
    int             random_items = 0;
    bit             random_phase = 1'b0;

    byte_pattern_range_search_unit uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_cmd            (i_cmd),
        .i_data_byte      (i_data_byte),
        .i_range_start    (i_range_start),
        .i_range_length   (i_range_length),
        .i_backwards      (i_backwards),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_found          (o_found),
        .o_match_location (o_match_location),
        .o_match_length   (o_match_length)
    );

    // Random values cut to the field widths
    function automatic logic [BYTE_W-1:0] rnd_byte();
        logic [31:0] r;
        r = $urandom;
        return r[BYTE_W-1:0];
    endfunction

    function automatic logic [LOC_W-1:0] rnd_loc();
        logic [31:0] r;
        r = $urandom;
        return r[LOC_W-1:0];
    endfunction

    function automatic logic [CMD_W-1:0] rnd_cmd();
        logic [31:0] r;
        r = $urandom;
        return r[CMD_W-1:0];
    endfunction

    function automatic logic rnd_bit();
        logic [31:0] r;
        r = $urandom;
        return r[0];
    endfunction

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #500_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Check every result transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0)
            board.check_match({o_found, o_match_location, o_match_length});
    end

    // Stall the result channel in changing patterns, with one long hold-off
    initial begin : receiver
        int mode;
        int span;
        int rx_cycles;
        int hold_at;
        bit held;
        rx_cycles = 0;
        held      = 1'b0;
        hold_at   = $urandom_range(200, 1500);
        forever begin
            mode = $urandom_range(0, 3);
            span = (mode == 3) ? $urandom_range(1, 12) : $urandom_range(1, 60);
            repeat (span) begin
                @(posedge i_clk);
                case (mode)
                    0:       i_stall <= 1'b0;
                    1:       i_stall <= ($urandom_range(0, 1) == 1);
                    2:       i_stall <= ($urandom_range(0, 6) != 0);
                    default: i_stall <= 1'b1;
                endcase
                if (random_phase)
                    rx_cycles++;
            end
            // hold off long enough for the block to back up into its input
            if (!held && rx_cycles >= hold_at) begin
                held = 1'b1;
                repeat (HOLD_CYCLES) begin
                    @(posedge i_clk);
                    i_stall <= 1'b1;
                end
            end
        end
    end

    // Offer one transaction and hold it until accepted, then maybe close the burst
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data,
                             input logic [LOC_W-1:0] start, input logic [LOC_W-1:0] span,
                             input logic back);
        int gap;
        i_valid        <= 1'b1;
        i_cmd          <= cmd;
        i_data_byte    <= data;
        i_range_start  <= start;
        i_range_length <= span;
        i_backwards    <= back;
        @(posedge i_clk);
        while (o_stall !== 1'b0)
            @(posedge i_clk);
        board.take_command(cmd, data, start, span, back);
        if (random_phase)
            random_items++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 23);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                // drop valid and scramble the idle payload
                i_valid        <= 1'b0;
                i_cmd          <= rnd_cmd();
                i_data_byte    <= rnd_byte();
                i_range_start  <= rnd_loc();
                i_range_length <= rnd_loc();
                i_backwards    <= rnd_bit();
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Search a random range, mostly near the filled part of the haystack
    task automatic issue_search();
        logic [LOC_W-1:0] start;
        logic [LOC_W-1:0] span;
        int unsigned      top;
        top = board.hay_fill + 2;
        case ($urandom_range(0, 9))
            0:       start = rnd_loc();
            1:       start = LOC_W'(board.hay_fill);
            default: start = LOC_W'($urandom_range(0, top));
        endcase
        case ($urandom_range(0, 9))
            0:       span = LOC_MAX;
            1:       span = rnd_loc();
            default: span = LOC_W'($urandom_range(0, top));
        endcase
        send_item(CMD_SEARCH, rnd_byte(), start, span, rnd_bit());
    endtask

    // Load a short haystack and needle over a small alphabet, then search it
    task automatic run_pattern_case();
        logic [BYTE_W-1:0] alpha [4];
        int                asz;
        int                nh;
        int                nn;
        int                p;
        for (int i = 0; i < 4; i++)
            alpha[i] = rnd_byte();
        asz = $urandom_range(1, 4);
        nh  = $urandom_range(0, 40);
        if (board.hay_fill + nh > SMALL_HAY || $urandom_range(0, 3) != 0)
            send_item(CMD_CLEAR_HAY, rnd_byte(), rnd_loc(), rnd_loc(), rnd_bit());
        repeat (nh)
            send_item(CMD_APPEND_HAY, alpha[$urandom_range(0, asz - 1)],
                      rnd_loc(), rnd_loc(), rnd_bit());
        // keep the old needle now and then, as long as it is short
        if (board.needle_fill > 5 || $urandom_range(0, 7) != 0)
            send_item(CMD_CLEAR_NEEDLE, rnd_byte(), rnd_loc(), rnd_loc(), rnd_bit());
        nn = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 66) : $urandom_range(0, 5);
        if (nn <= board.hay_fill && $urandom_range(0, 1) == 1) begin
            p = $urandom_range(0, board.hay_fill - nn);
            for (int k = 0; k < nn; k++)
                send_item(CMD_APPEND_NEEDLE, board.hay_bytes[p + k],
                          rnd_loc(), rnd_loc(), rnd_bit());
        end else begin
            repeat (nn)
                send_item(CMD_APPEND_NEEDLE, alpha[$urandom_range(0, asz - 1)],
                          rnd_loc(), rnd_loc(), rnd_bit());
        end
        repeat ($urandom_range(1, 6))
            issue_search();
    endtask

    // Any command, spare codes included, with random fields
    task automatic run_noise_case();
        logic [CMD_W-1:0] cmd;
        repeat ($urandom_range(4, 16)) begin
            cmd = rnd_cmd();
            if (cmd == CMD_SEARCH)
                issue_search();
            else
                send_item(cmd, rnd_byte(), rnd_loc(), rnd_loc(), rnd_bit());
        end
    endtask

    // Fill the needle past capacity and search a longer haystack with it
    task automatic run_full_buffer_case();
        int p;
        send_item(CMD_CLEAR_HAY, rnd_byte(), rnd_loc(), rnd_loc(), rnd_bit());
        repeat (FULL_CASE_HAY)
            send_item(CMD_APPEND_HAY, rnd_byte(), rnd_loc(), rnd_loc(), rnd_bit());
        // full needle copied from the haystack; the extra byte is dropped
        send_item(CMD_CLEAR_NEEDLE, rnd_byte(), rnd_loc(), rnd_loc(), rnd_bit());
        p = $urandom_range(0, FULL_CASE_HAY - NEEDLE_DEPTH);
        for (int k = 0; k < NEEDLE_DEPTH; k++)
            send_item(CMD_APPEND_NEEDLE, board.hay_bytes[p + k],
                      rnd_loc(), rnd_loc(), rnd_bit());
        send_item(CMD_APPEND_NEEDLE, rnd_byte(), rnd_loc(), rnd_loc(), rnd_bit());
        send_item(CMD_SEARCH, rnd_byte(), 0, LOC_MAX, 1'b0);
        send_item(CMD_SEARCH, rnd_byte(), 0, LOC_MAX, 1'b1);
        send_item(CMD_SEARCH, rnd_byte(), LOC_W'(p), LOC_W'(NEEDLE_DEPTH), 1'b1);
        send_item(CMD_SEARCH, rnd_byte(), LOC_W'(FULL_CASE_HAY), LOC_MAX, 1'b0);
        send_item(CMD_SEARCH, rnd_byte(), LOC_W'(FULL_CASE_HAY + 1), 0, 1'b1);
        // one-byte needle taken from the last haystack byte
        send_item(CMD_CLEAR_NEEDLE, rnd_byte(), rnd_loc(), rnd_loc(), rnd_bit());
        send_item(CMD_APPEND_NEEDLE, board.hay_bytes[FULL_CASE_HAY - 1],
                  rnd_loc(), rnd_loc(), rnd_bit());
        repeat (6)
            issue_search();
        // empty needle at the end of the haystack, backwards over all of it and forward from the fill
        send_item(CMD_CLEAR_NEEDLE, rnd_byte(), rnd_loc(), rnd_loc(), rnd_bit());
        send_item(CMD_SEARCH, rnd_byte(), 0, LOC_MAX, 1'b1);
        send_item(CMD_SEARCH, rnd_byte(), LOC_W'(FULL_CASE_HAY), LOC_MAX, 1'b0);
    endtask

    // Reset, directed checks, random traffic, drain
    initial begin : stimulus
        int big_at;
        bit big_done;
        board = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty buffers: empty needle at the start, start past the end
        send_item(CMD_SEARCH, 8'h00, 0, 0, 1'b0);
        send_item(CMD_SEARCH, 8'h00, 1, 0, 1'b1);
        // spare codes do nothing
        send_item(CMD_SPARE_5, 8'hFF, LOC_MAX, LOC_MAX, 1'b1);
        send_item(CMD_SPARE_6, 8'h00, 0, LOC_MAX, 1'b0);
        send_item(CMD_SPARE_7, 8'hFF, LOC_MAX, 0, 1'b1);
        send_item(CMD_APPEND_HAY, 8'h00, 0, 0, 1'b0);
        send_item(CMD_APPEND_HAY, 8'hFF, LOC_MAX, LOC_MAX, 1'b1);
        send_item(CMD_APPEND_HAY, 8'hA5, 0, 0, 1'b0);
        send_item(CMD_APPEND_HAY, 8'h00, 0, 0, 1'b0);
        send_item(CMD_APPEND_HAY, 8'hFF, 0, 0, 1'b0);
        // empty needle: range end backwards, start equal to the fill
        send_item(CMD_SEARCH, 8'h00, 1, LOC_MAX, 1'b1);
        send_item(CMD_SEARCH, 8'h00, 5, 0, 1'b0);
        send_item(CMD_APPEND_NEEDLE, 8'h00, 0, 0, 1'b0);
        send_item(CMD_APPEND_NEEDLE, 8'hFF, 0, 0, 1'b0);
        // first and last match, short range, start far past the end
        send_item(CMD_SEARCH, 8'h00, 0, LOC_MAX, 1'b0);
        send_item(CMD_SEARCH, 8'h00, 0, LOC_MAX, 1'b1);
        send_item(CMD_SEARCH, 8'h00, 4, LOC_MAX, 1'b0);
        send_item(CMD_SEARCH, 8'hFF, LOC_MAX, LOC_MAX, 1'b1);
        send_item(CMD_CLEAR_NEEDLE, 8'h00, 0, 0, 1'b0);
        send_item(CMD_SEARCH, 8'h00, 0, 2, 1'b1);
        // needle absent from the haystack
        send_item(CMD_APPEND_NEEDLE, 8'h5A, 0, 0, 1'b0);
        send_item(CMD_SEARCH, 8'h00, 0, LOC_MAX, 1'b0);
        // empty haystack with a needle
        send_item(CMD_CLEAR_HAY, 8'h00, 0, 0, 1'b0);
        send_item(CMD_SEARCH, 8'h00, 0, 0, 1'b0);

        // random traffic; the full buffer case comes once at a random point
        random_phase = 1'b1;
        big_done     = 1'b0;
        big_at       = $urandom_range(0, 1200);
        while (random_items < RANDOM_ITEMS) begin
            if (!big_done && random_items >= big_at) begin
                run_full_buffer_case();
                big_done = 1'b1;
            end else if ($urandom_range(0, 5) == 0) begin
                run_noise_case();
            end else begin
                run_pattern_case();
            end
        end
        i_valid <= 1'b0;

        // drain outstanding results
        while (board.pending.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
